/* rtl/lrutc_pkg.sv */
package lrutc_pkg;

    localparam int CACHE_ENTRIES_DEF = 512;
    localparam int STAMP_BITS_DEF    = 32;

    localparam int ID_W   = 16;
    localparam int KEY_W  = 2 * ID_W;
    localparam int SLOT_W = 9;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_INSERTED = 2'd2,
        ST_DISABLED = 2'd3
    } status_t;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } seq_state_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic start;
        logic vld;
    } scan_ctl_t;

endpackage

/* rtl/lrutc_ifs.sv */
interface lrutc_req_if;
    import lrutc_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [ID_W-1:0]   costume_id;
    logic [ID_W-1:0]   frame_number;

    modport source (output valid, command, costume_id, frame_number, input ready);
    modport sink   (input valid, command, costume_id, frame_number, output ready);
endinterface

interface lrutc_rsp_if;
    import lrutc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic              evicted;
    logic [ID_W-1:0]   evicted_costume_id;
    logic [ID_W-1:0]   evicted_frame;

    modport source (output valid, status, slot_index, evicted, evicted_costume_id,
                    evicted_frame, input ready);
    modport sink   (input valid, status, slot_index, evicted, evicted_costume_id,
                    evicted_frame, output ready);
endinterface

interface lrutc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/lrutc_tag_ram.sv */
module lrutc_tag_ram
    import lrutc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int STAMP_BITS    = STAMP_BITS_DEF,
    localparam int IDX_W        = $clog2(CACHE_ENTRIES)
)(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [KEY_W-1:0]      rd_key,
    output logic [STAMP_BITS-1:0] rd_stamp,
    input  logic                  wr_key_en,
    input  logic                  wr_stamp_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [KEY_W-1:0]      wr_key,
    input  logic [STAMP_BITS-1:0] wr_stamp
);

    logic [KEY_W-1:0]      key_mem   [CACHE_ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [CACHE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_stamp_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

endmodule

/* rtl/lrutc_scan.sv */
module lrutc_scan
    import lrutc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int STAMP_BITS    = STAMP_BITS_DEF,
    localparam int IDX_W        = $clog2(CACHE_ENTRIES)
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scan_ctl_t             ctl,
    input  logic [KEY_W-1:0]      req_key,
    input  logic [IDX_W-1:0]      rd_idx,
    input  logic [KEY_W-1:0]      rd_key,
    input  logic [STAMP_BITS-1:0] rd_stamp,
    output logic                  found,
    output logic [IDX_W-1:0]      found_idx,
    output logic [IDX_W-1:0]      min_idx,
    output logic [KEY_W-1:0]      min_key
);

    logic                  found_reg, found_next;
    logic                  have_min_reg, have_min_next;
    logic [IDX_W-1:0]      found_idx_reg, found_idx_next;
    logic [IDX_W-1:0]      min_idx_reg, min_idx_next;
    logic [KEY_W-1:0]      min_key_reg, min_key_next;
    logic [STAMP_BITS-1:0] min_stamp_reg, min_stamp_next;

    always_comb
    begin
        found_next     = found_reg;
        have_min_next  = have_min_reg;
        found_idx_next = found_idx_reg;
        min_idx_next   = min_idx_reg;
        min_key_next   = min_key_reg;
        min_stamp_next = min_stamp_reg;
        if (ctl.start)
        begin
            found_next    = 1'b0;
            have_min_next = 1'b0;
        end
        else if (ctl.vld)
        begin
            // keep the first match only
            if (!found_reg && rd_key == req_key)
            begin
                found_next     = 1'b1;
                found_idx_next = rd_idx;
            end
            // strict less: ties keep the lower slot
            if (!have_min_reg || rd_stamp < min_stamp_reg)
            begin
                have_min_next  = 1'b1;
                min_idx_next   = rd_idx;
                min_key_next   = rd_key;
                min_stamp_next = rd_stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            have_min_reg <= 1'b0;
        end
        else
        begin
            found_reg    <= found_next;
            have_min_reg <= have_min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        min_idx_reg   <= min_idx_next;
        min_key_reg   <= min_key_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign found     = found_reg;
    assign found_idx = found_idx_reg;
    assign min_idx   = min_idx_reg;
    assign min_key   = min_key_reg;

endmodule

/* rtl/lru_texture_cache_tags.sv */
// Tag and replacement controller for a fully associative texture cache.
// Channels: req (command, costume_id, frame_number) in, rsp (status,
// slot_index, evicted, evicted key) out, cfg writes the enable bit and is
// always ready. A lookup stamps a hit entry with the next use count; an
// insert refreshes a present key, fills the lowest free slot, or replaces
// the entry with the smallest stamp when all slots are in use.
// Each enabled request walks the filled tag/stamp RAM entries one entry per
// cycle through a single compare unit; a disabled request skips the walk.
// The RAM read port is the limit. One request is in flight at a time;
// req.ready is high only while the sequencer idles, so a new request is
// not taken until the last one has moved its result to the output register.
// A finished response sits in an output register, so the next request is
// accepted while rsp is stalled; its own result waits until that register
// is free.
// Reset clears the enable, the use counter and the fill count; slots below
// the fill count are the valid ones, so no RAM clearing pass is needed.
module lru_texture_cache_tags
    import lrutc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int STAMP_BITS    = STAMP_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    lrutc_req_if.sink   req,
    lrutc_rsp_if.source rsp,
    lrutc_cfg_if.sink   cfg
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    seq_state_t            state_reg, state_next;
    logic                  enabled_reg;
    command_t              cmd_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [CNT_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]      pipe_idx_reg;
    logic [STAMP_BITS-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    status_t               res_status_reg, res_status_next;
    logic [IDX_W-1:0]      res_slot_reg, res_slot_next;
    logic                  res_ev_reg, res_ev_next;
    logic [KEY_W-1:0]      res_ev_key_reg, res_ev_key_next;

    logic                  out_vld_reg;
    status_t               out_status_reg;
    logic [IDX_W-1:0]      out_slot_reg;
    logic                  out_ev_reg;
    logic [KEY_W-1:0]      out_ev_key_reg;

    logic                  accept;
    logic                  issue;
    logic                  out_load;
    logic [STAMP_BITS-1:0] stamp_new;
    logic                  full;

    scan_ctl_t             scan_ctl;
    logic                  wr_key_en, wr_stamp_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_W-1:0]      rd_key;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic                  found;
    logic [IDX_W-1:0]      found_idx, min_idx;
    logic [KEY_W-1:0]      min_key;

    assign accept    = req.valid && req.ready;
    assign issue     = (state_reg == S_SCAN) && (scan_addr_reg < count_reg);
    assign out_load  = (state_reg == S_DONE) && (!out_vld_reg || rsp.ready);
    assign stamp_new = counter_reg + STAMP_BITS'(1);
    assign full      = (count_reg == CNT_W'(CACHE_ENTRIES));

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = enabled_reg ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (!issue && !pipe_vld_reg)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb
    begin
        scan_ctl.start  = 1'b0;
        scan_ctl.vld    = pipe_vld_reg;
        scan_addr_next  = scan_addr_reg;
        pipe_vld_next   = 1'b0;
        counter_next    = counter_reg;
        count_next      = count_reg;
        wr_key_en       = 1'b0;
        wr_stamp_en     = 1'b0;
        wr_addr         = found_idx;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_ev_next     = res_ev_reg;
        res_ev_key_next = res_ev_key_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_ctl.start  = 1'b1;
                    scan_addr_next  = '0;
                    res_status_next = ST_DISABLED;
                    res_slot_next   = '0;
                    res_ev_next     = 1'b0;
                    res_ev_key_next = '0;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    pipe_vld_next  = 1'b1;
                end
            end
            S_UPDATE:
            begin
                if (cmd_reg == CMD_LOOKUP)
                begin
                    if (found)
                    begin
                        counter_next    = stamp_new;
                        wr_stamp_en     = 1'b1;
                        res_status_next = ST_HIT;
                        res_slot_next   = found_idx;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                    end
                end
                else
                begin
                    counter_next    = stamp_new;
                    wr_stamp_en     = 1'b1;
                    res_status_next = ST_INSERTED;
                    if (found)
                    begin
                        res_slot_next = found_idx;
                    end
                    else if (!full)
                    begin
                        wr_key_en     = 1'b1;
                        wr_addr       = count_reg[IDX_W-1:0];
                        res_slot_next = count_reg[IDX_W-1:0];
                        count_next    = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // replace the least recently used entry
                        wr_key_en       = 1'b1;
                        wr_addr         = min_idx;
                        res_slot_next   = min_idx;
                        res_ev_next     = 1'b1;
                        res_ev_key_next = min_key;
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            enabled_reg  <= 1'b0;
            pipe_vld_reg <= 1'b0;
            counter_reg  <= '0;
            count_reg    <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= pipe_vld_next;
            counter_reg  <= counter_next;
            count_reg    <= count_next;
            if (cfg.valid)
            begin
                enabled_reg <= cfg.data;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command_t'(req.command);
            key_reg <= {req.costume_id, req.frame_number};
        end
        scan_addr_reg  <= scan_addr_next;
        pipe_idx_reg   <= scan_addr_reg[IDX_W-1:0];
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_ev_reg     <= res_ev_next;
        res_ev_key_reg <= res_ev_key_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_ev_reg     <= res_ev_reg;
            out_ev_key_reg <= res_ev_key_reg;
        end
    end

    lrutc_tag_ram #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .STAMP_BITS    (STAMP_BITS)
    ) u_tag_ram (
        .clk         (clk),
        .rd_en       (issue),
        .rd_addr     (scan_addr_reg[IDX_W-1:0]),
        .rd_key      (rd_key),
        .rd_stamp    (rd_stamp),
        .wr_key_en   (wr_key_en),
        .wr_stamp_en (wr_stamp_en),
        .wr_addr     (wr_addr),
        .wr_key      (key_reg),
        .wr_stamp    (stamp_new)
    );

    lrutc_scan #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .STAMP_BITS    (STAMP_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .req_key   (key_reg),
        .rd_idx    (pipe_idx_reg),
        .rd_key    (rd_key),
        .rd_stamp  (rd_stamp),
        .found     (found),
        .found_idx (found_idx),
        .min_idx   (min_idx),
        .min_key   (min_key)
    );

    assign rsp.valid              = out_vld_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.slot_index         = SLOT_W'(out_slot_reg);
    assign rsp.evicted            = out_ev_reg;
    assign rsp.evicted_costume_id = out_ev_key_reg[KEY_W-1:ID_W];
    assign rsp.evicted_frame      = out_ev_key_reg[ID_W-1:0];

endmodule
